### rtl/c3br_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3br_pkg
// Shared types and codes of the 3x3 convolution, bias and ReLU stream core.
// ----------------------------------------------------------------------------
package c3br_pkg;

  // default sizing
  localparam int IN_CH_MAX_DEF = 8;
  localparam int OUT_CH_DEF    = 8;
  localparam int IMG_MAX_DEF   = 16;

  // window and lane constants
  localparam int WIN       = 3;
  localparam int NUM_TAPS  = WIN * WIN;
  localparam int OUT_LANES = 8;

  // operation codes of an input word
  localparam logic [1:0] OP_PIXEL  = 2'd0;
  localparam logic [1:0] OP_WEIGHT = 2'd1;
  localparam logic [1:0] OP_BIAS   = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W     = 2;
  localparam int          CFG_DATA_W    = 5;
  localparam logic [1:0]  CFG_HEIGHT    = 2'd0;
  localparam logic [1:0]  CFG_WIDTH     = 2'd1;
  localparam logic [1:0]  CFG_CHANNELS  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic [2:0]         out_channel;
    logic [2:0]         in_channel;
    logic [3:0]         tap;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  out_row;
    logic [3:0]  out_col;
    logic [30:0] chan0;
    logic [30:0] chan1;
    logic [30:0] chan2;
    logic [30:0] chan3;
    logic [30:0] chan4;
    logic [30:0] chan5;
    logic [30:0] chan6;
    logic [30:0] chan7;
    logic        frame_last;
  } out_word_t;

endpackage

### rtl/conv3x3_bias_relu_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_bias_relu_stream_core
// 3x3 multi-channel convolution with bias and ReLU over a streamed image.
// ----------------------------------------------------------------------------
// Load words and pixel words that do not close a pixel are stored and leave
// the input ready. A pixel word that closes a pixel (its last channel) then
// runs the shared MAC sequencer, one lane per output channel, once per
// output position that the pixel completes: it reads, multiplies and
// accumulates all nch*9 taps, drains the pipeline and emits, where nch is
// the channel count in use. The last pixel of a frame completes up to nine
// positions. The line store has one read port, so one tap of one input
// channel is read per cycle and feeds all output channel lanes at once. The
// input is not ready while positions are being computed; a finished output
// word waits in an output register, and the emit cycle stretches while the
// receiver holds it off.
module conv3x3_bias_relu_stream_core
  import c3br_pkg::*;
#(
  parameter int IN_CH_MAX = IN_CH_MAX_DEF,
  parameter int OUT_CH    = OUT_CH_DEF,
  parameter int IMG_MAX   = IMG_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW        = $clog2(IMG_MAX);
  localparam int CW        = (IN_CH_MAX > 1) ? $clog2(IN_CH_MAX) : 1;
  localparam int ROW_WORDS = IMG_MAX * IN_CH_MAX;
  localparam int LS_DEPTH  = WIN * ROW_WORDS;
  localparam int LS_AW     = $clog2(LS_DEPTH);
  localparam int W_DEPTH   = IN_CH_MAX * NUM_TAPS;
  localparam int WAW       = $clog2(W_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_EMIT} state_t;

  state_t state;

  // configuration registers
  logic [4:0] reg_h, reg_w;
  logic [3:0] reg_c;

  // stream position
  logic [PW-1:0] y, x;
  logic [1:0]    yslot;
  logic [CW-1:0] chan_pos;

  // emission bookkeeping
  logic [PW-1:0] ey, r, c, r_hi, c_lo, c_hi;
  logic [1:0]    eslot;
  logic [CW-1:0] k;
  logic [1:0]    ti, tj;

  // pipeline control
  logic q_v, q_inb, q_last, p_v, p_inb, p_last;

  logic [31:0] line_mem [LS_DEPTH];
  logic [31:0] ls_q;
  logic [31:0] w_q  [OUT_CH];
  logic [31:0] prod [OUT_CH];
  logic [31:0] acc  [OUT_CH];
  logic [31:0] bias [OUT_CH];

  // clamp registers to their usable range
  int            h_lim, w_lim, c_lim;
  logic [PW-1:0] hm1, wm1;
  logic [CW-1:0] nchm1;

  always_comb begin
    h_lim = (reg_h == 5'd0) ? 1 : ((int'(reg_h) > IMG_MAX) ? IMG_MAX : int'(reg_h));
    w_lim = (reg_w == 5'd0) ? 1 : ((int'(reg_w) > IMG_MAX) ? IMG_MAX : int'(reg_w));
    c_lim = (reg_c == 4'd0) ? 1 : ((int'(reg_c) > IN_CH_MAX) ? IN_CH_MAX : int'(reg_c));
    hm1   = PW'(h_lim - 1);
    wm1   = PW'(w_lim - 1);
    nchm1 = CW'(c_lim - 1);
  end

  // decode accepted word
  logic in_acc, acc_pix, pix_done;
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign acc_pix  = in_acc && (in_data.operation == OP_PIXEL);
  assign pix_done = acc_pix && (chan_pos == nchm1);

  // rows and columns whose window closes at this pixel
  logic          rows_ok, cols_ok, emit_any;
  logic [PW-1:0] r_lo_n, r_hi_n, c_lo_n, c_hi_n;

  always_comb begin
    rows_ok = (y == hm1) || (y >= PW'(2));
    cols_ok = (x == wm1) || (x >= PW'(2));
    r_lo_n  = (y >= PW'(2)) ? y - PW'(2) : '0;
    r_hi_n  = (y == hm1) ? y : y - PW'(2);
    c_lo_n  = (x >= PW'(2)) ? x - PW'(2) : '0;
    c_hi_n  = (x == wm1) ? x : x - PW'(2);
    emit_any = rows_ok && cols_ok;
  end

  // output handshake and sequencing flags
  logic out_free, last_pos, last_tap, start_pos;
  assign out_free  = !out_valid || out_ready;
  assign last_pos  = (r == r_hi) && (c == c_hi);
  assign last_tap  = (ti == 2'd2) && (tj == 2'd2) && (k == nchm1);
  assign start_pos = (pix_done && emit_any) || (state == ST_EMIT && out_free && !last_pos);

  // tap address generation
  logic [PW:0]       rr, cc;
  logic              inb;
  logic [1:0]        d2, rslot;
  logic [LS_AW-1:0]  ls_raddr, ls_waddr;
  logic [WAW-1:0]    w_raddr;

  always_comb begin
    rr       = {1'b0, r} + {{(PW-1){1'b0}}, ti};
    cc       = {1'b0, c} + {{(PW-1){1'b0}}, tj};
    inb      = (rr <= {1'b0, hm1}) && (cc <= {1'b0, wm1});
    d2       = 2'({1'b0, ey} - rr);
    rslot    = (eslot >= d2) ? eslot - d2 : eslot + 2'd3 - d2;
    ls_raddr = LS_AW'(rslot) * LS_AW'(ROW_WORDS) + LS_AW'(cc[PW-1:0]) * LS_AW'(IN_CH_MAX)
             + LS_AW'(k);
    ls_waddr = LS_AW'(yslot) * LS_AW'(ROW_WORDS) + LS_AW'(x) * LS_AW'(IN_CH_MAX)
             + LS_AW'(chan_pos);
    w_raddr  = WAW'(k) * WAW'(NUM_TAPS) + WAW'(ti) * WAW'(WIN) + WAW'(tj);
  end

  // line store
  always_ff @(posedge clk) begin
    if (acc_pix) begin
      line_mem[ls_waddr] <= in_data.value;
    end
    ls_q <= line_mem[ls_raddr];
  end

  // weight load decode
  logic           w_load_ok;
  logic [WAW-1:0] w_waddr;
  assign w_load_ok = in_acc && (in_data.operation == OP_WEIGHT)
                   && (int'(in_data.out_channel) < OUT_CH)
                   && (int'(in_data.in_channel) < IN_CH_MAX)
                   && (in_data.tap < 4'(NUM_TAPS));
  assign w_waddr = WAW'(in_data.in_channel) * WAW'(NUM_TAPS) + WAW'(in_data.tap);

  // per output channel lane: weight store, bias, multiply, accumulate
  for (genvar o = 0; o < OUT_CH; o++) begin : g_lane
    logic [31:0] wmem [W_DEPTH];

    always_ff @(posedge clk) begin
      if (w_load_ok && (int'(in_data.out_channel) == o)) begin
        wmem[w_waddr] <= in_data.value;
      end
      w_q[o] <= wmem[w_raddr];
    end

    always_ff @(posedge clk) begin
      if (in_acc && (in_data.operation == OP_BIAS) && (int'(in_data.out_channel) == o)) begin
        bias[o] <= in_data.value;
      end
      prod[o] <= ls_q * w_q[o];
      if (start_pos) begin
        acc[o] <= bias[o];
      end else if (p_v) begin
        acc[o] <= acc[o] + (p_inb ? prod[o] : 32'd0);
      end
    end
  end

  // activated lane results, unused lanes read zero
  logic [30:0] lane_res [OUT_LANES];
  for (genvar o = 0; o < OUT_LANES; o++) begin : g_res
    if (o < OUT_CH) begin : g_used
      assign lane_res[o] = acc[o][31] ? 31'd0 : acc[o][30:0];
    end else begin : g_zero
      assign lane_res[o] = 31'd0;
    end
  end

  // sequencer, positions, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      reg_h     <= 5'd16;
      reg_w     <= 5'd16;
      reg_c     <= 4'd8;
      y         <= '0;
      x         <= '0;
      yslot     <= '0;
      chan_pos  <= '0;
      q_v       <= 1'b0;
      p_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // advance the read pipeline
      q_v    <= (state == ST_ISSUE);
      q_inb  <= inb;
      q_last <= last_tap;
      p_v    <= q_v;
      p_inb  <= q_inb;
      p_last <= q_last;

      // drop a taken word unless the emit step refills the register
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      // configuration write to height, width or channels restarts the frame
      if (cfg_write) begin
        case (cfg_index)
          CFG_HEIGHT:   reg_h <= cfg_data;
          CFG_WIDTH:    reg_w <= cfg_data;
          CFG_CHANNELS: reg_c <= cfg_data[3:0];
          default: ;
        endcase
        if (cfg_index == CFG_HEIGHT || cfg_index == CFG_WIDTH || cfg_index == CFG_CHANNELS) begin
          y        <= '0;
          x        <= '0;
          yslot    <= '0;
          chan_pos <= '0;
        end
      end

      case (state)
        ST_IDLE: begin
          if (acc_pix) begin
            if (pix_done) begin
              chan_pos <= '0;
              ey       <= y;
              eslot    <= yslot;
              r        <= r_lo_n;
              r_hi     <= r_hi_n;
              c        <= c_lo_n;
              c_lo     <= c_lo_n;
              c_hi     <= c_hi_n;
              k        <= '0;
              ti       <= '0;
              tj       <= '0;
              if (emit_any) begin
                state <= ST_ISSUE;
              end
              if (x == wm1) begin
                x <= '0;
                if (y == hm1) begin
                  y     <= '0;
                  yslot <= '0;
                end else begin
                  y     <= y + PW'(1);
                  yslot <= (yslot == 2'd2) ? 2'd0 : yslot + 2'd1;
                end
              end else begin
                x <= x + PW'(1);
              end
            end else begin
              chan_pos <= chan_pos + CW'(1);
            end
          end
        end

        ST_ISSUE: begin
          // step tap column, tap row, then channel
          if (last_tap) begin
            state <= ST_DRAIN;
          end
          if (tj == 2'd2) begin
            tj <= '0;
            if (ti == 2'd2) begin
              ti <= '0;
              k  <= k + CW'(1);
            end else begin
              ti <= ti + 2'd1;
            end
          end else begin
            tj <= tj + 2'd1;
          end
        end

        ST_DRAIN: begin
          if (p_v && p_last) begin
            state <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_data.out_row    <= 4'(r);
            out_data.out_col    <= 4'(c);
            out_data.chan0      <= lane_res[0];
            out_data.chan1      <= lane_res[1];
            out_data.chan2      <= lane_res[2];
            out_data.chan3      <= lane_res[3];
            out_data.chan4      <= lane_res[4];
            out_data.chan5      <= lane_res[5];
            out_data.chan6      <= lane_res[6];
            out_data.chan7      <= lane_res[7];
            out_data.frame_last <= (r == hm1) && (c == wm1);
            k  <= '0;
            ti <= '0;
            tj <= '0;
            if (last_pos) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_ISSUE;
              if (c == c_hi) begin
                c <= c_lo;
                r <= r + PW'(1);
              end else begin
                c <= c + PW'(1);
              end
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
